FILE: sv/set_assoc_tlb_lru_unit_defines.svh
// Assertion macros for the translation buffer checker.
// No dependencies; included by the checker file only.
`ifndef SET_ASSOC_TLB_LRU_UNIT_DEFINES_SVH
`define SET_ASSOC_TLB_LRU_UNIT_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define SATLB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SATLB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/satlb_pkg.sv
// Shared types and constants of the set-associative translation buffer.
// No dependencies.
package satlb_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned VADDR_W = 48;
   localparam int unsigned FRAME_W = 36;
   localparam int unsigned TAG_W   = 32;
   localparam int unsigned PADDR_W = 48;
   localparam int unsigned RANK_W  = 3;

   localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PEEK      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [VADDR_W-1:0] vaddr;
      logic [FRAME_W-1:0] walk_frame;
      logic               walk_fault;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               fault;
      logic [PADDR_W-1:0] paddr;
      logic [RANK_W-1:0]  lru_rank;
   } rsp_type;

   typedef struct packed {
      logic               hit;
      logic               fault;
      logic               wr_en;
      logic               pa_en;
      logic [FRAME_W-1:0] frame;
      logic [RANK_W-1:0]  rank;
   } upd_result_type;

endpackage

FILE: sv/satlb_chan_if.sv
// Valid/ready channel carrying one payload per request.
// Payload type is given by the instantiating scope (see satlb_pkg).
interface satlb_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/set_assoc_tlb_lru_unit.sv
// Top level of the set-associative translation buffer with exact LRU ages.
// Depends on satlb_pkg, satlb_chan_if, satlb_ram, satlb_index_split, satlb_set_update.
//
//   channel    dir   payload                                     handshake
//   req_chan   in    command, vaddr, walk_frame, walk_fault      valid/ready
//   rsp_chan   out   hit, fault, paddr, lru_rank                 valid/ready
//
// Set index and tag: a bit split when SET_COUNT is a power of two; otherwise
//   a division in the index split (16 quotient bits a cycle).
// The set row is read from the RAM, updated and written back in the next cycle.
// Reset: all per-set live flags clear together; invalidate-all does the same.
// Stalls: a result waits in the output register while the next request is
//   accepted; its row read is issued once the output register is free.
module set_assoc_tlb_lru_unit #(
   parameter int unsigned PAGE_OFFSET_BITS = 12,
   parameter int unsigned SET_COUNT        = 16,
   parameter int unsigned WAY_COUNT        = 4,
   parameter int unsigned VADDR_BITS       = 48
) (
   input logic          clock,
   input logic          reset,
   satlb_chan_if.sink   req_chan,
   satlb_chan_if.source rsp_chan
);

   localparam int unsigned VA_W  = (VADDR_BITS < satlb_pkg::VADDR_W) ?
                                   VADDR_BITS : satlb_pkg::VADDR_W;
   localparam int unsigned VPN_W = VA_W - PAGE_OFFSET_BITS;
   localparam int unsigned SET_W = $clog2(SET_COUNT);
   localparam int unsigned AGE_W = $clog2(WAY_COUNT);
   localparam int unsigned ROW_W =
      WAY_COUNT * (1 + AGE_W + satlb_pkg::TAG_W + satlb_pkg::FRAME_W);
   localparam int unsigned PADDR_W = satlb_pkg::PADDR_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SPLIT  = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]                state_ff, state_in;
   satlb_pkg::req_type        item_ff, item_in;
   logic                      out_valid_ff, out_valid_in;
   satlb_pkg::rsp_type        out_data_ff, out_data_in;
   logic [SET_COUNT-1:0]      row_live_ff, row_live_in;

   logic                        req_fire;
   logic                        rsp_fire;
   logic                        issue_rd;
   logic                        load;
   logic                        split_done;
   logic [SET_W-1:0]            split_set;
   logic [satlb_pkg::TAG_W-1:0] split_tag;
   logic [ROW_W-1:0]            rd_row;
   logic [ROW_W-1:0]            wr_row;
   satlb_pkg::upd_result_type   upd;
   logic [PADDR_W+satlb_pkg::FRAME_W+PAGE_OFFSET_BITS-1:0] pa_ext;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign issue_rd       = (state_ff == ST_SPLIT) && split_done && (!out_valid_ff || rsp_fire);
   assign load           = (state_ff == ST_UPDATE);

   satlb_index_split #(
      .VPN_W     (VPN_W),
      .SET_COUNT (SET_COUNT)
   ) u_split (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire),
      .vpn     (req_chan.data.vaddr[VA_W-1:PAGE_OFFSET_BITS]),
      .done    (split_done),
      .set_idx (split_set),
      .tag     (split_tag)
   );

   satlb_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SET_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (load && upd.wr_en),
      .wr_addr (split_set),
      .wr_data (wr_row),
      .rd_en   (issue_rd),
      .rd_addr (split_set),
      .rd_data (rd_row)
   );

   satlb_set_update #(
      .WAY_COUNT (WAY_COUNT)
   ) u_update (
      .cmd        (item_ff.command),
      .tag        (split_tag),
      .walk_frame (item_ff.walk_frame),
      .walk_fault (item_ff.walk_fault),
      .row_live   (row_live_ff[split_set]),
      .rd_row     (rd_row),
      .wr_row     (wr_row),
      .result     (upd)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (issue_rd) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign item_in = req_fire ? req_chan.data : item_ff;
   assign pa_ext  = {{PADDR_W{1'b0}}, upd.frame, item_ff.vaddr[PAGE_OFFSET_BITS-1:0]};

   always_comb begin
      out_data_in          = out_data_ff;
      out_data_in.hit      = upd.hit;
      out_data_in.fault    = upd.fault;
      out_data_in.paddr    = upd.pa_en ? pa_ext[PADDR_W-1:0] : '0;
      out_data_in.lru_rank = upd.rank;
      if (!load) begin
         out_data_in = out_data_ff;
      end
   end

   assign out_valid_in = load ? 1'b1 : (rsp_fire ? 1'b0 : out_valid_ff);

   always_comb begin
      row_live_in = row_live_ff;
      if (load) begin
         if (item_ff.command == satlb_pkg::CMD_CLEAR) begin
            row_live_in = '0;
         end else if (upd.wr_en) begin
            row_live_in[split_set] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         row_live_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         row_live_ff  <= row_live_in;
      end
      item_ff     <= item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

endmodule

FILE: sv/satlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module satlb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/satlb_index_split.sv
// Splits a virtual page number into set index (remainder) and tag (quotient).
// Power-of-two set counts split by bit selection; others take one 16-bit quotient digit
// a cycle by reciprocal multiplication. Depends on satlb_pkg.
module satlb_index_split #(
   parameter int unsigned VPN_W     = 36,
   parameter int unsigned SET_COUNT = 16,
   localparam int unsigned SET_W = $clog2(SET_COUNT)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [VPN_W-1:0]            vpn,
   output logic                        done,
   output logic [SET_W-1:0]            set_idx,
   output logic [satlb_pkg::TAG_W-1:0] tag
);

   localparam int unsigned TAG_W   = satlb_pkg::TAG_W;
   localparam bit          IS_POW2 = (SET_COUNT == (1 << SET_W));

   logic             done_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;

   if (IS_POW2) begin : g_pow2
      logic [VPN_W+TAG_W-1:0] vpn_ext;

      assign vpn_ext = {{TAG_W{1'b0}}, vpn};

      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else if (start) begin
            done_ff <= 1'b1;
         end
         if (start) begin
            set_ff <= vpn[SET_W-1:0];
            tag_ff <= vpn_ext[SET_W +: TAG_W];
         end
      end
   end else begin : g_div
      localparam int unsigned STEP  = 16;
      localparam int unsigned ITERS = (VPN_W + STEP - 1) / STEP;
      localparam int unsigned DIV_W = ITERS * STEP;
      localparam int unsigned CNT_W = $clog2(ITERS + 1);
      localparam int unsigned X_W   = SET_W + STEP;
      localparam int unsigned SHIFT = X_W + SET_W;
      localparam int unsigned RCP_W = X_W + 1;
      localparam int unsigned PRD_W = X_W + RCP_W;
      localparam longint unsigned RCP_VAL =
         ((64'd1 << SHIFT) + 64'(SET_COUNT) - 64'd1) / 64'(SET_COUNT);
      localparam logic [RCP_W-1:0] RECIP   = RCP_W'(RCP_VAL);
      localparam logic [SET_W:0]   DIVISOR = (SET_W + 1)'(SET_COUNT);

      logic [DIV_W-1:0] dividend_ff;
      logic [CNT_W-1:0] count_ff;
      logic [X_W-1:0]   x_val;
      logic [PRD_W-1:0] prod;
      logic [STEP-1:0]  q_digit;
      logic [X_W-1:0]   q_times_d;
      logic [X_W-1:0]   r_full;
      logic [SET_W-1:0] rem_in;
      logic [TAG_W-1:0] quo_in;
      logic [DIV_W-1:0] dividend_in;

      // one digit a cycle, MSB first; exact for x below SET_COUNT << STEP
      assign x_val       = {set_ff, dividend_ff[DIV_W-1 -: STEP]};
      assign prod        = PRD_W'(x_val) * PRD_W'(RECIP);
      assign q_digit     = prod[SHIFT +: STEP];
      assign q_times_d   = X_W'(q_digit) * X_W'(DIVISOR);
      assign r_full      = x_val - q_times_d;
      assign rem_in      = r_full[SET_W-1:0];
      assign quo_in      = {tag_ff[TAG_W-STEP-1:0], q_digit};
      assign dividend_in = dividend_ff << STEP;

      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff  <= 1'b0;
            count_ff <= '0;
         end else if (start) begin
            done_ff  <= 1'b0;
            count_ff <= CNT_W'(ITERS);
         end else if (count_ff != '0) begin
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
         if (start) begin
            dividend_ff <= DIV_W'(vpn);
            set_ff      <= '0;
            tag_ff      <= '0;
         end else if (count_ff != '0) begin
            dividend_ff <= dividend_in;
            set_ff      <= rem_in;
            tag_ff      <= quo_in;
         end
      end
   end

   assign done    = done_ff;
   assign set_idx = set_ff;
   assign tag     = tag_ff;

endmodule

FILE: sv/satlb_set_update.sv
// Per-set lookup and read-modify-write of one row (all ways of a set).
// Tag compare, LRU promote, victim choice and fill. Depends on satlb_pkg.
module satlb_set_update #(
   parameter int unsigned WAY_COUNT = 4,
   localparam int unsigned AGE_W = $clog2(WAY_COUNT),
   localparam int unsigned ROW_W =
      WAY_COUNT * (1 + AGE_W + satlb_pkg::TAG_W + satlb_pkg::FRAME_W)
) (
   input  logic [satlb_pkg::CMD_W-1:0]   cmd,
   input  logic [satlb_pkg::TAG_W-1:0]   tag,
   input  logic [satlb_pkg::FRAME_W-1:0] walk_frame,
   input  logic                          walk_fault,
   input  logic                          row_live,
   input  logic [ROW_W-1:0]              rd_row,
   output logic [ROW_W-1:0]              wr_row,
   output satlb_pkg::upd_result_type     result
);

   localparam int unsigned RANK_W = satlb_pkg::RANK_W;
   localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(WAY_COUNT - 1);

   typedef struct packed {
      logic                          valid;
      logic [AGE_W-1:0]              age;
      logic [satlb_pkg::TAG_W-1:0]   tag;
      logic [satlb_pkg::FRAME_W-1:0] frame;
   } way_type;

   way_type [WAY_COUNT-1:0] cur;
   way_type [WAY_COUNT-1:0] nxt;
   logic    [WAY_COUNT-1:0] way_v;
   logic    [WAY_COUNT-1:0] match;
   logic                    hit;
   logic    [AGE_W-1:0]     hit_way;
   logic    [AGE_W-1:0]     hit_age;
   logic                    any_free;
   logic    [AGE_W-1:0]     free_way;
   logic    [AGE_W-1:0]     oldest_way;
   logic    [AGE_W-1:0]     victim;
   logic    [RANK_W:0]      rank_wide;

   assign cur = rd_row;

   always_comb begin
      for (int w = 0; w < WAY_COUNT; w++) begin
         way_v[w] = row_live && cur[w].valid;
         match[w] = way_v[w] && (cur[w].tag == tag);
      end
   end

   // lowest-numbered match / free way wins
   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      any_free = 1'b0;
      free_way = '0;
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = AGE_W'(w);
         end
         if (!way_v[w]) begin
            any_free = 1'b1;
            free_way = AGE_W'(w);
         end
      end
   end

   always_comb begin
      oldest_way = '0;
      for (int w = 1; w < WAY_COUNT; w++) begin
         if (cur[w].age > cur[oldest_way].age) begin
            oldest_way = AGE_W'(w);
         end
      end
   end

   assign victim    = any_free ? free_way : oldest_way;
   assign hit_age   = cur[hit_way].age;
   assign rank_wide = (RANK_W + 1)'(hit_age) + (RANK_W + 1)'(1);

   always_comb begin
      nxt    = cur;
      result = '0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         nxt[w].valid = way_v[w];
      end
      case (cmd)
         satlb_pkg::CMD_TRANSLATE: begin
            if (hit) begin
               result.hit   = 1'b1;
               result.wr_en = 1'b1;
               result.pa_en = 1'b1;
               result.frame = cur[hit_way].frame;
               for (int w = 0; w < WAY_COUNT; w++) begin
                  if (way_v[w] && (cur[w].age < hit_age)) begin
                     nxt[w].age = cur[w].age + 1'b1;
                  end
               end
               nxt[hit_way].age = '0;
            end else if (walk_fault) begin
               result.fault = 1'b1;
            end else begin
               result.wr_en = 1'b1;
               result.pa_en = 1'b1;
               result.frame = walk_frame;
               for (int w = 0; w < WAY_COUNT; w++) begin
                  if (way_v[w] && (AGE_W'(w) != victim) && (cur[w].age < AGE_TOP)) begin
                     nxt[w].age = cur[w].age + 1'b1;
                  end
               end
               nxt[victim].valid = 1'b1;
               nxt[victim].age   = '0;
               nxt[victim].tag   = tag;
               nxt[victim].frame = walk_frame;
            end
         end
         satlb_pkg::CMD_PEEK: begin
            if (hit) begin
               result.hit  = 1'b1;
               result.rank = rank_wide[RANK_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_row = nxt;

endmodule

FILE: sv/satlb_checker.sv
// Port-level assertions for set_assoc_tlb_lru_unit, attached by bind.
// Depends on satlb_pkg and set_assoc_tlb_lru_unit_defines.svh.
`include "set_assoc_tlb_lru_unit_defines.svh"

module satlb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_hit,
   input logic                          rsp_fault,
   input logic [satlb_pkg::PADDR_W-1:0] rsp_paddr,
   input logic [satlb_pkg::RANK_W-1:0]  rsp_lru_rank
);

   `SATLB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_fault) && $stable(rsp_paddr) && $stable(rsp_lru_rank), "response changed while stalled")
   `SATLB_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "request accepted while one is in progress")
   `SATLB_ASSERT(a_fault_clean, clock, reset, rsp_valid && rsp_fault |-> !rsp_hit && rsp_paddr == '0 && rsp_lru_rank == '0, "fault response carries data")
   `SATLB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response pending after reset")

endmodule

bind set_assoc_tlb_lru_unit satlb_checker u_satlb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_hit      (rsp_chan.data.hit),
   .rsp_fault    (rsp_chan.data.fault),
   .rsp_paddr    (rsp_chan.data.paddr),
   .rsp_lru_rank (rsp_chan.data.lru_rank)
);

FILE: sim/tb_set_assoc_tlb_lru_unit.sv
`timescale 1ns / 1ps
// Testbench for set_assoc_tlb_lru_unit: directed and random translate, peek, clear and unused requests.
// Depends on satlb_pkg, satlb_chan_if and the unit; a shadow TLB class predicts each response.
module tb_set_assoc_tlb_lru_unit;

   localparam int unsigned OFFSET_BITS = 12;
   localparam int unsigned SETS        = 16;
   localparam int unsigned WAYS        = 4;
   localparam int unsigned VA_BITS     = 48;
   localparam int unsigned TAG_BITS    = satlb_pkg::TAG_W;
   localparam int unsigned FRAME_BITS  = satlb_pkg::FRAME_W;

   localparam logic [satlb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   class tlb_shadow;
      bit [TAG_BITS-1:0]   tags   [SETS][WAYS];
      bit [FRAME_BITS-1:0] frames [SETS][WAYS];
      bit                  live   [SETS][WAYS];
      bit [1:0]            ages   [SETS][WAYS];
      satlb_pkg::rsp_type  expected_rsps [$];
      int                  mismatches;

      function int lookup(int set_idx, bit [TAG_BITS-1:0] tag);
         for (int w = 0; w < WAYS; w++) begin
            if (live[set_idx][w] && tags[set_idx][w] == tag) return w;
         end
         return -1;
      endfunction

      function void note_request(satlb_pkg::req_type rq);
         satlb_pkg::rsp_type want;
         bit [35:0]          vpn;
         bit [11:0]          off;
         bit [TAG_BITS-1:0]  tag;
         bit [1:0]           cur;
         int                 set_idx;
         int                 way;
         want    = '0;
         vpn     = rq.vaddr[VA_BITS-1:OFFSET_BITS];
         off     = rq.vaddr[OFFSET_BITS-1:0];
         set_idx = int'(vpn[3:0]);
         tag     = vpn[35:4];
         case (rq.command)
            satlb_pkg::CMD_TRANSLATE: begin
               way = lookup(set_idx, tag);
               if (way >= 0) begin
                  cur = ages[set_idx][way];
                  for (int w = 0; w < WAYS; w++) begin
                     if (live[set_idx][w] && ages[set_idx][w] < cur) ages[set_idx][w]++;
                  end
                  ages[set_idx][way] = '0;
                  want.hit   = 1'b1;
                  want.paddr = {frames[set_idx][way], off};
               end else if (rq.walk_fault) begin
                  want.fault = 1'b1;
               end else begin
                  way = -1;
                  for (int w = 0; w < WAYS; w++) begin
                     if (way < 0 && !live[set_idx][w]) way = w;
                  end
                  if (way < 0) begin
                     way = 0;
                     for (int w = 1; w < WAYS; w++) begin
                        if (ages[set_idx][w] > ages[set_idx][way]) way = w;
                     end
                  end
                  tags[set_idx][way]   = tag;
                  frames[set_idx][way] = rq.walk_frame;
                  live[set_idx][way]   = 1'b1;
                  for (int w = 0; w < WAYS; w++) begin
                     if (live[set_idx][w] && w != way && ages[set_idx][w] < WAYS - 1)
                        ages[set_idx][w]++;
                  end
                  ages[set_idx][way] = '0;
                  want.paddr = {rq.walk_frame, off};
               end
            end
            satlb_pkg::CMD_PEEK: begin
               way = lookup(set_idx, tag);
               if (way >= 0) begin
                  want.hit      = 1'b1;
                  want.lru_rank = {1'b0, ages[set_idx][way]} + 3'd1;
               end
            end
            satlb_pkg::CMD_CLEAR: begin
               for (int s = 0; s < SETS; s++)
                  for (int w = 0; w < WAYS; w++) live[s][w] = 1'b0;
            end
            default: ;
         endcase
         expected_rsps.push_back(want);
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_response(satlb_pkg::rsp_type got);
         satlb_pkg::rsp_type want;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no request pending", 64'(got), 64'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.hit !== want.hit)
               report_mismatch("hit", 64'(got.hit), 64'(want.hit));
            if (got.fault !== want.fault)
               report_mismatch("fault", 64'(got.fault), 64'(want.fault));
            if (got.paddr !== want.paddr)
               report_mismatch("paddr", 64'(got.paddr), 64'(want.paddr));
            if (got.lru_rank !== want.lru_rank)
               report_mismatch("lru_rank", 64'(got.lru_rank), 64'(want.lru_rank));
         end
      endtask

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle;
   int   recv_idle;
   bit [TAG_BITS-1:0] pool_tags [6];
   tlb_shadow shadow;

   satlb_chan_if #(.payload_type(satlb_pkg::req_type)) req_if ();
   satlb_chan_if #(.payload_type(satlb_pkg::rsp_type)) rsp_if ();

   set_assoc_tlb_lru_unit #(
      .PAGE_OFFSET_BITS(OFFSET_BITS),
      .SET_COUNT(SETS),
      .WAY_COUNT(WAYS),
      .VADDR_BITS(VA_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
         if (rsp_if.valid && rsp_if.ready) shadow.check_response(rsp_if.data);
      end
   end

   function satlb_pkg::req_type mk_req(logic [satlb_pkg::CMD_W-1:0] cmd,
                                       bit [TAG_BITS-1:0] tag, bit [3:0] set_idx,
                                       bit [11:0] off, bit [FRAME_BITS-1:0] frame,
                                       bit flt);
      satlb_pkg::req_type rq;
      rq.command    = cmd;
      rq.vaddr      = {tag, set_idx, off};
      rq.walk_frame = frame;
      rq.walk_fault = flt;
      return rq;
   endfunction

   function satlb_pkg::req_type random_request();
      satlb_pkg::req_type rq;
      logic [63:0]        r;
      int                 p;
      bit [3:0]           set_idx;
      r             = {$urandom, $urandom};
      rq.walk_frame = r[FRAME_BITS-1:0];
      r             = {$urandom, $urandom};
      p             = $urandom_range(0, 99);
      if (p < 4) begin
         rq.command    = 2'($urandom);
         rq.vaddr      = r[VA_BITS-1:0];
         rq.walk_fault = 1'($urandom);
      end else begin
         if (p < 72) rq.command = satlb_pkg::CMD_TRANSLATE;
         else if (p < 94) rq.command = satlb_pkg::CMD_PEEK;
         else if (p < 97) rq.command = satlb_pkg::CMD_CLEAR;
         else rq.command = CMD_UNUSED;
         if ($urandom_range(0, 9) == 0) set_idx = 4'($urandom);
         else set_idx = 4'($urandom_range(0, 3));
         rq.vaddr      = {pool_tags[$urandom_range(0, 5)], set_idx, r[11:0]};
         rq.walk_fault = ($urandom_range(0, 9) == 0);
      end
      return rq;
   endfunction

   task send_request(satlb_pkg::req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle && gap < 50) gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      do @(posedge clock); while (!req_if.ready);
      shadow.note_request(item);
   endtask

   task run_directed();
      int t;
      send_request(mk_req(satlb_pkg::CMD_PEEK, '0, '0, '0, '0, 1'b0));
      send_request(mk_req(satlb_pkg::CMD_TRANSLATE, '0, '0, 12'h000, '0, 1'b1));
      send_request(mk_req(satlb_pkg::CMD_TRANSLATE, '0, '0, 12'h000, '0, 1'b0));
      send_request(mk_req(satlb_pkg::CMD_TRANSLATE, '0, '0, 12'hFFF, '1, 1'b1));
      send_request(mk_req(satlb_pkg::CMD_TRANSLATE, '1, 4'hF, 12'hFFF, '1, 1'b0));
      send_request(mk_req(satlb_pkg::CMD_TRANSLATE, '1, 4'hF, 12'h000, '0, 1'b1));
      send_request(mk_req(satlb_pkg::CMD_PEEK, '1, 4'hF, 12'h000, '1, 1'b1));
      // fill set 0; the fourth new tag evicts the oldest way
      for (t = 1; t <= 4; t++)
         send_request(mk_req(satlb_pkg::CMD_TRANSLATE, 32'(t), '0, 12'h5A5,
                             36'h123456789 + 36'(t), 1'b0));
      for (t = 0; t <= 4; t++)
         send_request(mk_req(satlb_pkg::CMD_PEEK, 32'(t), '0, 12'(t), '0, 1'b0));
      send_request(mk_req(satlb_pkg::CMD_TRANSLATE, 32'd1, '0, 12'h001, '0, 1'b0));
      send_request(mk_req(satlb_pkg::CMD_PEEK, 32'd1, '0, 12'h000, '0, 1'b0));
      send_request(mk_req(CMD_UNUSED, '1, 4'hF, 12'hFFF, '1, 1'b1));
      send_request(mk_req(satlb_pkg::CMD_CLEAR, '1, 4'hF, 12'hFFF, '1, 1'b1));
      send_request(mk_req(satlb_pkg::CMD_PEEK, 32'd1, '0, 12'h000, '0, 1'b0));
      send_request(mk_req(satlb_pkg::CMD_TRANSLATE, '1, 4'hF, 12'h000, '0, 1'b1));
   endtask

   task run_phase(int count);
      satlb_pkg::req_type rq;
      int                 done;
      done = 0;
      while (done < count) begin
         rq = random_request();
         send_request(rq);
         if (rq.command != CMD_UNUSED) done++;
      end
   endtask

   initial begin
      shadow       = new();
      send_idle    = 16;
      recv_idle    = 69;
      pool_tags[0] = '0;
      pool_tags[1] = '1;
      for (int i = 2; i < 6; i++) pool_tags[i] = $urandom;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase(560);
      send_idle = 69;
      recv_idle = 16;
      run_phase(560);
      send_idle = 0;
      recv_idle = 0;
      run_phase(560);
      req_if.valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+sv
sv/satlb_pkg.sv
sv/satlb_chan_if.sv
sv/satlb_ram.sv
sv/satlb_index_split.sv
sv/satlb_set_update.sv
sv/set_assoc_tlb_lru_unit.sv
sv/satlb_checker.sv
sim/tb_set_assoc_tlb_lru_unit.sv
